// ===== design/ubxfr_pkg.sv =====
package ubxfr_pkg;

    localparam int PAYLOAD_CAPACITY_DEF = 256;
    localparam int FRAME_LEN_W          = 9;
    localparam int INDEX_EXT_W          = 11;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [2:0] {
        OP_BYTE     = 3'd0,
        OP_READ     = 3'd1,
        OP_ARM_ACK  = 3'd2,
        OP_ARM_POLL = 3'd3,
        OP_CANCEL   = 3'd4
    } t_op;

    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_OK      = 2'd1;
    localparam logic [1:0] ACK_REFUSED = 2'd2;

    localparam logic [1:0] CFG_ACK_CLASS = 2'd0;
    localparam logic [1:0] CFG_ACK_POS   = 2'd1;
    localparam logic [1:0] CFG_ACK_NEG   = 2'd2;

    typedef struct packed {
        logic [7:0] ack_class;
        logic [7:0] ack_pos;
        logic [7:0] ack_neg;
    } t_ack_cfg;

    typedef struct packed {
        logic                   done;
        logic                   bad;
        logic                   over;
        logic [7:0]             cls;
        logic [7:0]             id;
        logic [FRAME_LEN_W-1:0] len;
        logic                   len_is_two;
        logic [15:0]            first_two;
    } t_frame_evt;

    typedef struct packed {
        logic [7:0]             last_cls;
        logic [7:0]             last_id;
        logic [FRAME_LEN_W-1:0] last_len;
        logic [1:0]             ack_status;
        logic                   ack_waiting;
        logic                   poll_done;
        logic [FRAME_LEN_W-1:0] poll_len;
    } t_status;

endpackage

// ===== design/ubxfr_ram.sv =====
module ubxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ubxfr_parser.sv =====
module ubxfr_parser
    import ubxfr_pkg::*;
#(
    parameter int PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [7:0]                          i_byte,
    output logic                                o_wr_en,
    output logic [$clog2(PAYLOAD_CAPACITY)-1:0] o_wr_addr,
    output logic [7:0]                          o_wr_data,
    output t_frame_evt                          o_evt
);

    localparam int AW = $clog2(PAYLOAD_CAPACITY);
    localparam int CW = $clog2(PAYLOAD_CAPACITY + 1);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_HEADER  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_CKA     = 6'b010000,
        PH_CKB     = 6'b100000
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [1:0]     r_hcnt, n_hcnt;
    logic [7:0]     r_cls, n_cls;
    logic [7:0]     r_id, n_id;
    logic [7:0]     r_len_lo, n_len_lo;
    logic [CW-1:0]  r_plen, n_plen;
    logic [CW-1:0]  r_pcnt, n_pcnt;
    logic [15:0]    r_first, n_first;
    logic [7:0]     r_sum_a, n_sum_a;
    logic [7:0]     r_sum_b, n_sum_b;
    logic [7:0]     r_got_a, n_got_a;

    logic           restart;
    logic           wr_phase;
    logic [7:0]     sum_a_add;
    logic [7:0]     sum_b_add;
    logic [15:0]    full_len;
    logic [CW-1:0]  pcnt_inc;
    t_frame_evt     evt;

    assign sum_a_add = r_sum_a + i_byte;
    assign sum_b_add = r_sum_b + sum_a_add;
    assign full_len  = {i_byte, r_len_lo};
    assign pcnt_inc  = r_pcnt + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_cls    = r_cls;
        n_id     = r_id;
        n_len_lo = r_len_lo;
        n_plen   = r_plen;
        n_pcnt   = r_pcnt;
        n_first  = r_first;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_got_a  = r_got_a;
        restart  = 1'b0;
        wr_phase = 1'b0;

        evt            = '0;
        evt.cls        = r_cls;
        evt.id         = r_id;
        evt.len        = FRAME_LEN_W'(r_plen);
        evt.len_is_two = (r_plen == CW'(2));
        evt.first_two  = r_first;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (i_byte == SYNC_SECOND) begin
                    restart = 1'b1;
                    n_phase = PH_HEADER;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HEADER: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_hcnt  = r_hcnt + 1'b1;
                unique case (r_hcnt)
                    2'd0: n_cls = i_byte;
                    2'd1: n_id = i_byte;
                    2'd2: n_len_lo = i_byte;
                    default: begin
                        if (full_len > 16'(PAYLOAD_CAPACITY)) begin
                            evt.over = 1'b1;
                            restart  = 1'b1;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_plen  = CW'(full_len);
                            n_phase = (full_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
                        end
                    end
                endcase
            end
            PH_PAYLOAD: begin
                wr_phase = 1'b1;
                if (r_pcnt == CW'(0)) begin
                    n_first[7:0] = i_byte;
                end
                if (r_pcnt == CW'(1)) begin
                    n_first[15:8] = i_byte;
                end
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_pcnt  = pcnt_inc;
                if (pcnt_inc >= r_plen) begin
                    n_phase = PH_CKA;
                end
            end
            PH_CKA: begin
                n_got_a = i_byte;
                n_phase = PH_CKB;
            end
            PH_CKB: begin
                if (r_got_a == r_sum_a && i_byte == r_sum_b) begin
                    evt.done = 1'b1;
                end else begin
                    evt.bad = 1'b1;
                end
                restart = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                restart = 1'b1;
                n_phase = PH_IDLE;
            end
        endcase

        if (restart) begin
            n_hcnt  = '0;
            n_plen  = '0;
            n_pcnt  = '0;
            n_sum_a = '0;
            n_sum_b = '0;
            n_got_a = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hcnt   <= '0;
            r_cls    <= '0;
            r_id     <= '0;
            r_len_lo <= '0;
            r_plen   <= '0;
            r_pcnt   <= '0;
            r_first  <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_got_a  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_cls    <= n_cls;
            r_id     <= n_id;
            r_len_lo <= n_len_lo;
            r_plen   <= n_plen;
            r_pcnt   <= n_pcnt;
            r_first  <= n_first;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_got_a  <= n_got_a;
        end
    end

    assign o_wr_en   = i_step && wr_phase;
    assign o_wr_addr = r_pcnt[AW-1:0];
    assign o_wr_data = i_byte;
    assign o_evt     = evt;

endmodule

// ===== design/ubxfr_track.sv =====
module ubxfr_track
    import ubxfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [2:0] i_op,
    input  logic [7:0] i_expect_class,
    input  logic [7:0] i_expect_id,
    input  t_frame_evt i_evt,
    input  t_ack_cfg   i_cfg,
    output t_status    o_status
);

    t_status    r_st, n_st;
    logic [7:0] r_ack_cls, n_ack_cls;
    logic [7:0] r_ack_id, n_ack_id;
    logic       r_poll_wait, n_poll_wait;
    logic [7:0] r_poll_cls, n_poll_cls;
    logic [7:0] r_poll_id, n_poll_id;
    logic       ack_shape;

    assign ack_shape = i_evt.cls == i_cfg.ack_class && i_evt.len_is_two &&
                       (i_evt.id == i_cfg.ack_pos || i_evt.id == i_cfg.ack_neg);

    always_comb begin
        n_st        = r_st;
        n_ack_cls   = r_ack_cls;
        n_ack_id    = r_ack_id;
        n_poll_wait = r_poll_wait;
        n_poll_cls  = r_poll_cls;
        n_poll_id   = r_poll_id;

        if (i_step) begin
            unique case (i_op)
                OP_BYTE: begin
                    if (i_evt.done) begin
                        n_st.last_cls = i_evt.cls;
                        n_st.last_id  = i_evt.id;
                        n_st.last_len = i_evt.len;
                        if (ack_shape) begin
                            if (r_st.ack_waiting && i_evt.first_two[7:0] == r_ack_cls &&
                                i_evt.first_two[15:8] == r_ack_id) begin
                                n_st.ack_status  = (i_evt.id == i_cfg.ack_pos) ?
                                                   ACK_OK : ACK_REFUSED;
                                n_st.ack_waiting = 1'b0;
                            end
                        end else if (r_poll_wait && i_evt.cls == r_poll_cls &&
                                     i_evt.id == r_poll_id) begin
                            n_st.poll_done = 1'b1;
                            n_st.poll_len  = i_evt.len;
                            n_poll_wait    = 1'b0;
                        end
                    end
                end
                OP_ARM_ACK: begin
                    n_ack_cls        = i_expect_class;
                    n_ack_id         = i_expect_id;
                    n_st.ack_status  = ACK_NONE;
                    n_st.ack_waiting = 1'b1;
                end
                OP_ARM_POLL: begin
                    n_poll_cls     = i_expect_class;
                    n_poll_id      = i_expect_id;
                    n_st.poll_done = 1'b0;
                    n_st.poll_len  = '0;
                    n_poll_wait    = 1'b1;
                end
                OP_CANCEL: begin
                    n_ack_cls        = '0;
                    n_ack_id         = '0;
                    n_st.ack_status  = ACK_NONE;
                    n_st.ack_waiting = 1'b0;
                    n_poll_cls       = '0;
                    n_poll_id        = '0;
                    n_st.poll_done   = 1'b0;
                    n_st.poll_len    = '0;
                    n_poll_wait      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_ack_cls   <= '0;
            r_ack_id    <= '0;
            r_poll_wait <= 1'b0;
            r_poll_cls  <= '0;
            r_poll_id   <= '0;
        end else begin
            r_st        <= n_st;
            r_ack_cls   <= n_ack_cls;
            r_ack_id    <= n_ack_id;
            r_poll_wait <= n_poll_wait;
            r_poll_cls  <= n_poll_cls;
            r_poll_id   <= n_poll_id;
        end
    end

    assign o_status = n_st;

endmodule

// ===== design/ubx_frame_receiver.sv =====
// UBX frame receiver.
// Input channel (i_in_valid / o_in_stall) carries one item per op: a received
// byte, a payload read by index, arming the acknowledge or poll wait, or a
// cancel of both waits. Every item yields exactly one result item on the output
// channel (o_out_valid / i_out_stall) with the per-byte flags, the last good
// frame info, the wait status and the read byte.
// o_out_valid rises once an item has passed the input register and then the result
// register; the item waits in the input register while the result register is held.
// Throughput: one item per cycle while i_out_stall is low, set by the single pass
// of parser and wait logic between those two registers; the payload store is a
// one-write, one-read RAM read during acceptance.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets the acknowledge
// class and the positive and negative ids; write it only while idle.
// Reset (synchronous, active low) empties the pipeline, returns the parser to
// sync hunting and clears frame info, waits and configuration to defaults. The
// payload store is not cleared; only bytes of received frames may be read.
// When i_out_stall is high the result holds; one more item can sit in the input
// register, after which o_in_stall rises until the result is taken.
module ubx_frame_receiver
    import ubxfr_pkg::*;
#(
    parameter int PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [2:0]             i_op,
    input  logic [7:0]             i_rx_byte,
    input  logic [7:0]             i_expect_class,
    input  logic [7:0]             i_expect_id,
    input  logic [7:0]             i_read_index,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_frame_done,
    output logic [7:0]             o_frame_class,
    output logic [7:0]             o_frame_id,
    output logic [FRAME_LEN_W-1:0] o_frame_length,
    output logic [1:0]             o_ack_status,
    output logic                   o_ack_waiting,
    output logic                   o_poll_done,
    output logic [FRAME_LEN_W-1:0] o_poll_length,
    output logic [7:0]             o_read_data,
    output logic                   o_checksum_failed,
    output logic                   o_oversize_dropped,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    localparam int AW = $clog2(PAYLOAD_CAPACITY);

    logic          accept;
    logic          advance;
    logic          out_free;
    logic          step_byte;
    logic          in_range;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    ram_q;
    logic [7:0]    rd_byte;
    t_frame_evt    evt;
    t_status       status;

    t_ack_cfg      r_cfg;

    logic          r_s1_vld;
    logic [2:0]    r_s1_op;
    logic [7:0]    r_s1_byte;
    logic [7:0]    r_s1_ecls;
    logic [7:0]    r_s1_eid;
    logic          r_s1_in_range;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;

    logic          r_out_vld;
    t_status       r_out_st;
    logic          r_out_done;
    logic          r_out_bad;
    logic          r_out_over;
    logic [7:0]    r_out_rdata;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign step_byte  = advance && r_s1_op == OP_BYTE;

    assign in_range = INDEX_EXT_W'(i_read_index) < INDEX_EXT_W'(PAYLOAD_CAPACITY);
    assign rd_addr  = AW'(i_read_index);

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_class <= 8'd5;
            r_cfg.ack_pos   <= 8'd1;
            r_cfg.ack_neg   <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ACK_CLASS: r_cfg.ack_class <= i_cfg_data;
                CFG_ACK_POS: r_cfg.ack_pos <= i_cfg_data;
                CFG_ACK_NEG: r_cfg.ack_neg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= i_op;
            r_s1_byte     <= i_rx_byte;
            r_s1_ecls     <= i_expect_class;
            r_s1_eid      <= i_expect_id;
            r_s1_in_range <= in_range;
            r_byp_hit     <= wr_en && wr_addr == rd_addr;
            r_byp_data    <= wr_data;
        end
    end

    ubxfr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    ubxfr_parser #(
        .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step_byte),
        .i_byte    (r_s1_byte),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_evt     (evt)
    );

    ubxfr_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_op           (r_s1_op),
        .i_expect_class (r_s1_ecls),
        .i_expect_id    (r_s1_eid),
        .i_evt          (evt),
        .i_cfg          (r_cfg),
        .o_status       (status)
    );

    assign rd_byte = r_byp_hit ? r_byp_data : ram_q;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_st    <= status;
            r_out_done  <= step_byte && evt.done;
            r_out_bad   <= step_byte && evt.bad;
            r_out_over  <= step_byte && evt.over;
            r_out_rdata <= (r_s1_op == OP_READ && r_s1_in_range) ? rd_byte : 8'd0;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_frame_done       = r_out_done;
    assign o_frame_class      = r_out_st.last_cls;
    assign o_frame_id         = r_out_st.last_id;
    assign o_frame_length     = r_out_st.last_len;
    assign o_ack_status       = r_out_st.ack_status;
    assign o_ack_waiting      = r_out_st.ack_waiting;
    assign o_poll_done        = r_out_st.poll_done;
    assign o_poll_length      = r_out_st.poll_len;
    assign o_read_data        = r_out_rdata;
    assign o_checksum_failed  = r_out_bad;
    assign o_oversize_dropped = r_out_over;

    a_done_xor_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_frame_done && o_checksum_failed))
        else $error("frame reported both good and bad");

    a_wait_no_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_waiting |-> o_ack_status == ACK_NONE)
        else $error("ack wait armed with an answer recorded");

    a_poll_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_poll_done |-> o_poll_length == '0)
        else $error("poll length set without poll answer");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_vld && r_out_vld)
        else $error("input stalled with free pipeline");

endmodule
